FILE: src/utrb_pkg.sv
// ----------------------------------------------------------------------------
// utrb_pkg
// Shared types, constants and helpers for the serial port ring buffer block.
// ----------------------------------------------------------------------------
package utrb_pkg;

   // ring geometry: each ring keeps one slot free
   localparam int RING_DEPTH = 64;
   localparam int PTR_W      = $clog2(RING_DEPTH);
   localparam int BYTE_W     = 8;

   // command queue between front and back
   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   // port widths
   localparam int FUNC_W    = 2;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 24;

   // request function codes
   localparam logic [FUNC_W-1:0] FUNC_PUT      = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_GET      = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_RECV     = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_TX_READY = 2'd3;

   typedef enum logic [1:0] {
      CMD_PUT,
      CMD_GET,
      CMD_RECV,
      CMD_TX_READY
   } cmd_kind_type;

   // one classified request
   typedef struct packed {
      cmd_kind_type           kind;
      logic [BYTE_W-1:0]      data;
   } cmd_type;

   // response word, first field in the highest bits
   typedef struct packed {
      logic                   tx_armed_now;
      logic                   rx_enabled_now;
      logic                   tx_has_room;
      logic                   rx_nonempty;
      logic                   rx_dropped;
      logic [BYTE_W-1:0]      line_tx_byte;
      logic                   line_tx_valid;
      logic [BYTE_W-1:0]      get_byte;
      logic                   get_valid;
      logic                   put_accepted;
   } rsp_type;

   // pointer advance with wrap
   function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] n;
      if (p == PTR_W'(RING_DEPTH - 1)) begin
         n = '0;
      end else begin
         n = p + PTR_W'(1);
      end
      return n;
   endfunction

endpackage

FILE: src/utrb_front.sv
// ----------------------------------------------------------------------------
// utrb_front
// Accepts requests and classifies them into commands for the queue.
// ----------------------------------------------------------------------------
module utrb_front (
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [7:0]                    req_tdata,   // byte_in
   input  logic [1:0]                    req_tuser,   // func
   input  logic                          q_full,
   output logic                          q_push,
   output utrb_pkg::cmd_type             q_cmd
);
   import utrb_pkg::*;

   // take a request whenever the queue has a free slot
   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full;

   // decode the function code, keep the byte only where it is used
   always_comb begin
      q_cmd.data = '0;
      case (req_tuser)
         FUNC_PUT: begin
            q_cmd.kind = CMD_PUT;
            q_cmd.data = req_tdata;
         end
         FUNC_GET: begin
            q_cmd.kind = CMD_GET;
         end
         FUNC_RECV: begin
            q_cmd.kind = CMD_RECV;
            q_cmd.data = req_tdata;
         end
         FUNC_TX_READY: begin
            q_cmd.kind = CMD_TX_READY;
         end
         default: begin
            q_cmd.kind = CMD_TX_READY;
         end
      endcase
   end

endmodule

FILE: src/utrb_cmd_queue.sv
// ----------------------------------------------------------------------------
// utrb_cmd_queue
// Short command queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module utrb_cmd_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  utrb_pkg::cmd_type             push_cmd,
   output logic                          full,
   input  logic                          pop,
   output logic                          head_valid,
   output utrb_pkg::cmd_type             head_cmd
);
   import utrb_pkg::*;

   cmd_type              slot_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]   count_ff, count_in;

   assign full       = (count_ff == Q_CNT_W'(Q_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = slot_ff[rd_ptr_ff];

   // pointer and level update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + Q_PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + Q_PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + Q_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - Q_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // slot storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

FILE: src/utrb_back.sv
// ----------------------------------------------------------------------------
// utrb_back
// Executes commands against the transmit and receive rings, builds responses.
// ----------------------------------------------------------------------------
module utrb_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          cmd_valid,
   input  utrb_pkg::cmd_type             cmd,
   output logic                          cmd_pop,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output utrb_pkg::rsp_type             rsp_tdata
);
   import utrb_pkg::*;

   typedef enum logic {
      B_IDLE,
      B_FIN
   } back_state_type;

   back_state_type       state_ff, state_in;
   logic [PTR_W-1:0]     tx_wr_ff, tx_wr_in;
   logic [PTR_W-1:0]     tx_rd_ff, tx_rd_in;
   logic [PTR_W-1:0]     rx_wr_ff, rx_wr_in;
   logic [PTR_W-1:0]     rx_rd_ff, rx_rd_in;
   logic                 rx_en_ff, rx_en_in;
   logic                 tx_arm_ff, tx_arm_in;
   rsp_type              pend_ff, pend_in;
   logic                 rsp_valid_ff;
   rsp_type              rsp_data_ff;
   rsp_type              fin_rsp;

   logic [BYTE_W-1:0]    tx_mem [RING_DEPTH];
   logic [BYTE_W-1:0]    rx_mem [RING_DEPTH];
   logic [BYTE_W-1:0]    tx_q_ff;
   logic [BYTE_W-1:0]    rx_q_ff;
   logic                 tx_we;
   logic                 rx_we;
   logic                 start;
   logic [PTR_W-1:0]     tx_wr_nxt;
   logic [PTR_W-1:0]     rx_wr_nxt;

   // start a command once the response slot is free by the finish cycle
   assign start   = (state_ff == B_IDLE) && cmd_valid && (!rsp_valid_ff || rsp_tready);
   assign cmd_pop = start;

   assign tx_wr_nxt = ring_next(tx_wr_ff);
   assign rx_wr_nxt = ring_next(rx_wr_ff);

   // command execution: pointers, flags and pending response fields
   always_comb begin
      state_in  = state_ff;
      tx_wr_in  = tx_wr_ff;
      tx_rd_in  = tx_rd_ff;
      rx_wr_in  = rx_wr_ff;
      rx_rd_in  = rx_rd_ff;
      rx_en_in  = rx_en_ff;
      tx_arm_in = tx_arm_ff;
      pend_in   = pend_ff;
      tx_we     = 1'b0;
      rx_we     = 1'b0;
      if (start) begin
         pend_in  = '0;
         state_in = B_FIN;
         case (cmd.kind)
            CMD_PUT: begin
               if (tx_wr_nxt != tx_rd_ff) begin
                  tx_we                = 1'b1;
                  tx_wr_in             = tx_wr_nxt;
                  tx_arm_in            = 1'b1;
                  pend_in.put_accepted = 1'b1;
               end
            end
            CMD_GET: begin
               if (rx_wr_ff != rx_rd_ff) begin
                  rx_rd_in          = ring_next(rx_rd_ff);
                  pend_in.get_valid = 1'b1;
               end
            end
            CMD_RECV: begin
               if (!rx_en_ff) begin
                  pend_in.rx_dropped = 1'b1;
               end else if (rx_wr_nxt == rx_rd_ff) begin
                  rx_en_in           = 1'b0;
                  pend_in.rx_dropped = 1'b1;
               end else begin
                  rx_we    = 1'b1;
                  rx_wr_in = rx_wr_nxt;
               end
            end
            CMD_TX_READY: begin
               if (tx_arm_ff) begin
                  if (tx_wr_ff == tx_rd_ff) begin
                     tx_arm_in = 1'b0;
                  end else begin
                     tx_rd_in              = ring_next(tx_rd_ff);
                     pend_in.line_tx_valid = 1'b1;
                  end
               end
            end
            default: begin
               pend_in = '0;
            end
         endcase
         // status after the step
         pend_in.rx_nonempty    = (rx_wr_in != rx_rd_in);
         pend_in.tx_has_room    = (ring_next(tx_wr_in) != tx_rd_in);
         pend_in.rx_enabled_now = rx_en_in;
         pend_in.tx_armed_now   = tx_arm_in;
      end else if (state_ff == B_FIN) begin
         state_in = B_IDLE;
      end
   end

   // finished response: pending fields plus the registered ring bytes
   always_comb begin
      fin_rsp              = pend_ff;
      fin_rsp.get_byte     = pend_ff.get_valid ? rx_q_ff : '0;
      fin_rsp.line_tx_byte = pend_ff.line_tx_valid ? tx_q_ff : '0;
   end

   // state, ring pointers and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         tx_wr_ff     <= '0;
         tx_rd_ff     <= '0;
         rx_wr_ff     <= '0;
         rx_rd_ff     <= '0;
         rx_en_ff     <= 1'b1;
         tx_arm_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rsp_data_ff  <= '0;
      end else begin
         state_ff  <= state_in;
         tx_wr_ff  <= tx_wr_in;
         tx_rd_ff  <= tx_rd_in;
         rx_wr_ff  <= rx_wr_in;
         rx_rd_ff  <= rx_rd_in;
         rx_en_ff  <= rx_en_in;
         tx_arm_ff <= tx_arm_in;
         if (state_ff == B_FIN) begin
            rsp_valid_ff <= 1'b1;
            rsp_data_ff  <= fin_rsp;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // pending response fields
   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
   end

   // transmit ring memory, read at the head pointer
   always_ff @(posedge clock) begin
      if (tx_we) begin
         tx_mem[tx_wr_ff] <= cmd.data;
      end
      tx_q_ff <= tx_mem[tx_rd_ff];
   end

   // receive ring memory, read at the head pointer
   always_ff @(posedge clock) begin
      if (rx_we) begin
         rx_mem[rx_wr_ff] <= cmd.data;
      end
      rx_q_ff <= rx_mem[rx_rd_ff];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

FILE: src/uart_tx_rx_ring_buffers.sv
// ----------------------------------------------------------------------------
// uart_tx_rx_ring_buffers
// Transmit and receive byte rings for a serial port, one response per request.
//
//   channel  direction  handshake              payload
//   req      in         req_tvalid/req_tready  tuser: func, tdata: byte_in
//   rsp      out        rsp_tvalid/rsp_tready  tdata: ten response fields
//
// In the back end each request first updates the ring pointers and issues
// the ring memory read (B_IDLE), then loads the registered read byte into
// the response register (B_FIN). The two-entry command queue keeps
// accepting requests while the back end works or the response waits.
// Reset is synchronous: rings empty, reception on, transmit request off.
// A stalled response holds the back end; the front stalls once the queue fills.
// ----------------------------------------------------------------------------
module uart_tx_rx_ring_buffers (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // byte_in
   input  logic [1:0]   req_tuser,   // func
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // put_accepted, get_valid, get_byte[7:0], line_tx_valid, line_tx_byte[7:0],
   // rx_dropped, rx_nonempty, tx_has_room, rx_enabled_now, tx_armed_now
   output logic [23:0]  rsp_tdata
);
   import utrb_pkg::*;

   logic     q_full;
   logic     q_push;
   cmd_type  q_cmd;
   logic     q_pop;
   logic     head_valid;
   cmd_type  head_cmd;
   rsp_type  rsp_word;

   // request classification
   utrb_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_cmd      (q_cmd)
   );

   // decoupling queue
   utrb_cmd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_cmd   (q_cmd),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   // ring execution
   utrb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (head_valid),
      .cmd        (head_cmd),
      .cmd_pop    (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_word)
   );

   assign rsp_tdata = rsp_word;

   // at most one action kind per response
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $onehot0({rsp_word.put_accepted, rsp_word.get_valid,
                               rsp_word.line_tx_valid, rsp_word.rx_dropped}))
      else $error("more than one action flagged in one response");

   // bytes are zero unless the matching valid flag is set
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_word.get_valid || rsp_word.get_byte == '0) &&
                      (rsp_word.line_tx_valid || rsp_word.line_tx_byte == '0)))
      else $error("response byte set without its valid flag");

   // a byte handed out leaves the transmit request armed
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_word.line_tx_valid) |-> rsp_word.tx_armed_now)
      else $error("transmit byte handed out while request disarmed");

endmodule

FILE: tb/uart_tx_rx_ring_buffers_tb.sv
// ----------------------------------------------------------------------------
// uart_tx_rx_ring_buffers_tb
// Self-checking bench for the serial port transmit and receive byte rings.
// Requests are driven on the req stream, and every response is compared
// field by field against a cycle-free prediction of both rings. The run covers
// directed corner cases, ring fill and wrap, random traffic with bursty stalls
// on both streams, a long response hold-off, receive overflow and a closing stretch.
// ----------------------------------------------------------------------------
module uart_tx_rx_ring_buffers_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import utrb_pkg::*;

   localparam int HOLD_CYCLES = 300;
   localparam int MAX_REPORTS = 100;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata = '0;    // byte_in
   logic [1:0]   req_tuser = '0;    // func
   logic         rsp_tvalid;
   logic         rsp_tready;
   // put_accepted, get_valid, get_byte[7:0], line_tx_valid, line_tx_byte[7:0],
   // rx_dropped, rx_nonempty, tx_has_room, rx_enabled_now, tx_armed_now
   logic [23:0]  rsp_tdata;

   // receiver side controls
   logic         sink_ready = 1'b1;
   logic         hold_active = 1'b0;
   logic         hold_start = 1'b0;
   bit           sink_idle_on = 1'b1;
   bit           src_idle_on = 1'b1;

   // predicted ring contents and control flags
   logic [7:0]   tx_ring [RING_DEPTH];
   logic [7:0]   rx_ring [RING_DEPTH];
   int           tx_wr = 0;
   int           tx_rd = 0;
   int           rx_wr = 0;
   int           rx_rd = 0;
   bit           rx_on = 1'b1;
   bit           tx_armed = 1'b0;

   rsp_type      expected_rsp [$];
   int           error_count = 0;
   int           rsp_count = 0;

   assign rsp_tready = sink_ready & ~hold_active;

   uart_tx_rx_ring_buffers i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // failure reporting
   task automatic report_failure(input string msg);
      if (error_count < MAX_REPORTS) begin
         $display("ERROR %0t: %s", $time, msg);
      end
      error_count++;
   endtask

   function automatic int tx_level();
      return (tx_wr - tx_rd + RING_DEPTH) % RING_DEPTH;
   endfunction

   function automatic int rx_level();
      return (rx_wr - rx_rd + RING_DEPTH) % RING_DEPTH;
   endfunction

   // advance both rings for one accepted request and queue the response
   task automatic predict_ring_step(input logic [1:0] func, input logic [7:0] data);
      rsp_type r;
      int      nxt;
      r = '0;
      case (func)
         FUNC_PUT: begin
            nxt = (tx_wr + 1) % RING_DEPTH;
            if (nxt != tx_rd) begin
               tx_ring[tx_wr] = data;
               tx_wr = nxt;
               tx_armed = 1'b1;
               r.put_accepted = 1'b1;
            end
         end
         FUNC_GET: begin
            if (rx_wr != rx_rd) begin
               r.get_byte = rx_ring[rx_rd];
               r.get_valid = 1'b1;
               rx_rd = (rx_rd + 1) % RING_DEPTH;
            end
         end
         FUNC_RECV: begin
            if (!rx_on) begin
               r.rx_dropped = 1'b1;
            end else if ((rx_wr + 1) % RING_DEPTH == rx_rd) begin
               // overflow shuts reception off for good
               rx_on = 1'b0;
               r.rx_dropped = 1'b1;
            end else begin
               rx_ring[rx_wr] = data;
               rx_wr = (rx_wr + 1) % RING_DEPTH;
            end
         end
         default: begin
            if (tx_armed) begin
               if (tx_wr == tx_rd) begin
                  tx_armed = 1'b0;
               end else begin
                  r.line_tx_byte = tx_ring[tx_rd];
                  r.line_tx_valid = 1'b1;
                  tx_rd = (tx_rd + 1) % RING_DEPTH;
               end
            end
         end
      endcase
      r.rx_nonempty = (rx_wr != rx_rd);
      r.tx_has_room = ((tx_wr + 1) % RING_DEPTH != tx_rd);
      r.rx_enabled_now = rx_on;
      r.tx_armed_now = tx_armed;
      expected_rsp.push_back(r);
   endtask

   // offer one request, with an optional idle burst ahead of it
   task automatic send_request(input logic [1:0] func, input logic [7:0] data);
      int gap;
      if (src_idle_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 18);
         @(negedge clock);
         req_tvalid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tuser = func;
      req_tdata = data;
      do @(posedge clock); while (!req_tready);
      predict_ring_step(func, data);
   endtask

   // stop offering and let every pending response come back
   task automatic wait_drained();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] rand_byte();
      return 8'($urandom_range(0, 255));
   endfunction

   // weighted random requests; reception is never overflowed here
   task automatic random_traffic(input int count, input int w_put, input int w_get,
                                 input int w_recv, input int w_rdy);
      int         pick;
      logic [1:0] func;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, w_put + w_get + w_recv + w_rdy - 1);
         if (pick < w_put) begin
            func = FUNC_PUT;
         end else if (pick < w_put + w_get) begin
            func = FUNC_GET;
         end else if (pick < w_put + w_get + w_recv) begin
            func = FUNC_RECV;
         end else begin
            func = FUNC_TX_READY;
         end
         if (func == FUNC_RECV && rx_on && rx_level() == RING_DEPTH - 1) begin
            func = FUNC_GET;
         end
         send_request(func, rand_byte());
      end
   endtask

   // corner cases on empty and nearly empty rings
   task automatic test_directed();
      send_request(FUNC_GET, 8'hFF);          // get from empty ring
      send_request(FUNC_TX_READY, 8'hFF);     // ready while not armed
      send_request(FUNC_RECV, 8'h00);
      send_request(FUNC_RECV, 8'hFF);
      send_request(FUNC_RECV, 8'hA5);
      send_request(FUNC_GET, 8'h00);
      send_request(FUNC_GET, 8'h00);
      send_request(FUNC_GET, 8'h00);
      send_request(FUNC_GET, 8'h5A);          // empty again
      send_request(FUNC_PUT, 8'h00);          // arms the request
      send_request(FUNC_PUT, 8'hFF);
      send_request(FUNC_TX_READY, 8'h00);
      send_request(FUNC_TX_READY, 8'h00);     // ring empties, stays armed
      send_request(FUNC_TX_READY, 8'h00);     // armed and empty: disarm
      send_request(FUNC_TX_READY, 8'h00);     // not armed
      send_request(FUNC_PUT, 8'h5A);
      send_request(FUNC_TX_READY, 8'hC3);
      send_request(FUNC_TX_READY, 8'h3C);
      wait_drained();
   endtask

   // fill the transmit ring, refuse one more, then drain it
   task automatic test_tx_full();
      while (tx_level() < RING_DEPTH - 1) send_request(FUNC_PUT, rand_byte());
      send_request(FUNC_PUT, 8'hEE);          // put into full ring
      while (tx_level() > 0) send_request(FUNC_TX_READY, rand_byte());
      send_request(FUNC_TX_READY, 8'h00);
   endtask

   // mixed traffic with phases that push each ring toward full and empty
   task automatic test_random_mix();
      random_traffic(300, 1, 1, 1, 1);
      random_traffic(150, 6, 1, 1, 2);
      random_traffic(150, 1, 1, 1, 6);
      random_traffic(150, 1, 1, 6, 1);
      random_traffic(150, 1, 6, 1, 1);
      sink_idle_on = 1'b0;
      src_idle_on = 1'b0;
      random_traffic(150, 2, 1, 2, 1);
      sink_idle_on = 1'b1;
      src_idle_on = 1'b1;
      random_traffic(150, 1, 2, 1, 2);
      random_traffic(200, 1, 1, 1, 1);
   endtask

   // long response hold-off while requests keep coming
   task automatic test_backpressure();
      wait_drained();
      hold_start = 1'b1;
      random_traffic(60, 1, 1, 1, 1);
      wait_drained();
   endtask

   // overflow the receive ring; reception stays off afterwards
   task automatic test_rx_overflow();
      while (rx_level() < RING_DEPTH - 1) send_request(FUNC_RECV, rand_byte());
      send_request(FUNC_RECV, 8'hC3);         // receive into full ring
      send_request(FUNC_GET, 8'h00);
      send_request(FUNC_RECV, 8'h3C);         // reception off, dropped
   endtask

   // final stretch without idling on either side
   task automatic test_tail();
      sink_idle_on = 1'b0;
      src_idle_on = 1'b0;
      random_traffic(160, 1, 1, 1, 1);
   endtask

   // response checking
   task automatic compare_field(input string field, input int got, input int want);
      if (got != want) begin
         report_failure($sformatf("response %0d %s got 0x%0h expected 0x%0h",
                                  rsp_count, field, got, want));
      end
   endtask

   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_type'(rsp_tdata);
         if (expected_rsp.size() == 0) begin
            report_failure($sformatf("unexpected response 0x%06h", rsp_tdata));
         end else begin
            want = expected_rsp.pop_front();
            compare_field("put_accepted", got.put_accepted, want.put_accepted);
            compare_field("get_valid", got.get_valid, want.get_valid);
            compare_field("get_byte", got.get_byte, want.get_byte);
            compare_field("line_tx_valid", got.line_tx_valid, want.line_tx_valid);
            compare_field("line_tx_byte", got.line_tx_byte, want.line_tx_byte);
            compare_field("rx_dropped", got.rx_dropped, want.rx_dropped);
            compare_field("rx_nonempty", got.rx_nonempty, want.rx_nonempty);
            compare_field("tx_has_room", got.tx_has_room, want.tx_has_room);
            compare_field("rx_enabled_now", got.rx_enabled_now, want.rx_enabled_now);
            compare_field("tx_armed_now", got.tx_armed_now, want.tx_armed_now);
         end
         rsp_count++;
      end
   end

   // random stall bursts on the response side
   always begin
      @(negedge clock);
      if (sink_idle_on && $urandom_range(0, 9) == 0) begin
         sink_ready = 1'b0;
         repeat ($urandom_range(1, 18)) @(negedge clock);
         sink_ready = 1'b1;
      end else begin
         sink_ready = 1'b1;
      end
   end

   // long hold-off, counted in cycles
   always begin
      @(negedge clock);
      if (hold_start) begin
         hold_start = 1'b0;
         hold_active = 1'b1;
         for (int i = 0; i < HOLD_CYCLES; i++) @(negedge clock);
         hold_active = 1'b0;
      end
   end

   // run limit
   initial begin
      #5ms;
      $display("Test completed with failures");
      $finish;
   end

   // test sequence
   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_tx_full();
      test_random_mix();
      test_backpressure();
      test_rx_overflow();
      test_tail();
      wait_drained();
      repeat (20) @(posedge clock);
      if (expected_rsp.size() != 0) begin
         report_failure($sformatf("%0d responses never arrived", expected_rsp.size()));
      end
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
